// ===== rtl/rbs_pkg.sv =====
package rbs_pkg;

  localparam int NUM_AXES   = 3;
  localparam int NUM_POINTS = 2 * NUM_AXES;

endpackage

// ===== rtl/rbs_div.sv =====
module rbs_div #(
  parameter int N = 49,
  parameter int D = 32
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic [N-1:0] quotient
);

  // Restoring division, one quotient bit per stage. Dividend bits leave the
  // top of dq while quotient bits enter at the bottom.
  logic [D-1:0] rem_r [N];
  logic [N-1:0] dq_r  [N];
  logic [D-1:0] dv_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D-1:0] rem_in;
    logic [D-1:0] dv_in;
    logic [N-1:0] dq_in;
    logic [D:0]   trial;
    logic [D:0]   diff;
    logic         ge;
    logic [D-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign dv_in  = divisor;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dq_in  = dq_r[k-1];
      assign dv_in  = dv_r[k-1];
    end

    assign trial   = {rem_in, dq_in[N-1]};
    assign diff    = trial - {1'b0, dv_in};
    assign ge      = trial >= {1'b0, dv_in};
    assign rem_nxt = ge ? diff[D-1:0] : trial[D-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        dq_r[k]  <= {dq_in[N-2:0], ge};
        dv_r[k]  <= dv_in;
      end
    end
  end

  assign quotient = dq_r[N-1];

endmodule

// ===== rtl/ray_box_slab_intersect.sv =====
// Throughput: one word per cycle while the output is not stalled, set by
// the six restoring dividers, pipelined at one quotient bit per stage.
// Reset clears the valid bits of every stage; no clearing pass is needed.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_ray_origin_x,
  input  logic signed [COORD_WIDTH-1:0] in_ray_origin_y,
  input  logic signed [COORD_WIDTH-1:0] in_ray_origin_z,
  input  logic signed [COORD_WIDTH-1:0] in_ray_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_ray_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_ray_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0] in_box_max_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic signed [COORD_WIDTH-1:0] out_entry_x,
  output logic signed [COORD_WIDTH-1:0] out_entry_y,
  output logic signed [COORD_WIDTH-1:0] out_entry_z,
  output logic signed [COORD_WIDTH-1:0] out_exit_x,
  output logic signed [COORD_WIDTH-1:0] out_exit_y,
  output logic signed [COORD_WIDTH-1:0] out_exit_z
);

  import rbs_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NW = W + F + 1;
  localparam int TW = NW + 1;
  localparam int HL = (NW + 1) / 2;
  localparam int HH = NW - HL;
  localparam int PW = NW + W;
  localparam int QW = PW - F;
  localparam int SW = 2 * NUM_AXES * W + 3 * NUM_AXES;

  logic en;

  // Input register.
  logic signed [W-1:0] o0_r [NUM_AXES];
  logic signed [W-1:0] d0_r [NUM_AXES];
  logic signed [W-1:0] lo0_r [NUM_AXES];
  logic signed [W-1:0] hi0_r [NUM_AXES];
  logic                v0_r;

  logic signed [W:0]   dlo_nxt [NUM_AXES];
  logic signed [W:0]   dhi_nxt [NUM_AXES];
  logic [W:0]          mlo_nxt [NUM_AXES];
  logic [W:0]          mhi_nxt [NUM_AXES];
  logic [W-1:0]        md_nxt [NUM_AXES];
  logic [NUM_AXES-1:0] neglo_nxt;
  logic [NUM_AXES-1:0] neghi_nxt;
  logic [NUM_AXES-1:0] skip_nxt;
  logic [SW-1:0]       side_nxt;

  logic [NW-1:0] qlo [NUM_AXES];
  logic [NW-1:0] qhi [NUM_AXES];

  logic [SW-1:0] side_r [NW];
  logic [NW-1:0] sv_r;

  logic signed [W-1:0] os [NUM_AXES];
  logic signed [W-1:0] ds [NUM_AXES];
  logic [NUM_AXES-1:0] nlos;
  logic [NUM_AXES-1:0] nhis;
  logic [NUM_AXES-1:0] skips;

  // Signed distances.
  logic signed [TW-1:0] t1_r [NUM_AXES];
  logic signed [TW-1:0] t2_r [NUM_AXES];
  logic signed [W-1:0]  oc_r [NUM_AXES];
  logic signed [W-1:0]  dc_r [NUM_AXES];
  logic [NUM_AXES-1:0]  skipc_r;
  logic                 vc_r;

  // Near and far per axis.
  logic signed [TW-1:0] near_r [NUM_AXES];
  logic signed [TW-1:0] far_r [NUM_AXES];
  logic signed [W-1:0]  od_r [NUM_AXES];
  logic signed [W-1:0]  dd_r [NUM_AXES];
  logic [NUM_AXES-1:0]  skipd_r;
  logic                 vd_r;

  // Entry and exit distances.
  logic signed [TW-1:0] tin_nxt;
  logic signed [TW-1:0] tout_nxt;
  logic                 any_nxt;
  logic signed [TW-1:0] tin_r;
  logic signed [TW-1:0] tout_r;
  logic signed [W-1:0]  oe_r [NUM_AXES];
  logic signed [W-1:0]  de_r [NUM_AXES];
  logic                 hite_r;
  logic                 ve_r;

  // Magnitudes and signs for the products.
  logic [TW-1:0]         amin_nxt;
  logic [TW-1:0]         amout_nxt;
  logic [NW-1:0]         mtin_r;
  logic [NW-1:0]         mtout_r;
  logic [W-1:0]          mdf_r [NUM_AXES];
  logic [NUM_POINTS-1:0] negf_r;
  logic signed [W-1:0]   of_r [NUM_AXES];
  logic                  hitf_r;
  logic                  vf_r;

  // Partial products.
  logic [HL+W-1:0]       plo_r [NUM_POINTS];
  logic [HH+W-1:0]       phi_r [NUM_POINTS];
  logic [NUM_POINTS-1:0] negg_r;
  logic signed [W-1:0]   og_r [NUM_AXES];
  logic                  hitg_r;
  logic                  vg_r;

  // Full products.
  logic [PW-1:0]         prod_r [NUM_POINTS];
  logic [NUM_POINTS-1:0] negh_r;
  logic signed [W-1:0]   oh_r [NUM_AXES];
  logic                  hith_r;
  logic                  vh_r;

  // Points.
  logic signed [W-1:0] pt_nxt [NUM_POINTS];
  logic signed [W-1:0] pt_r [NUM_POINTS];
  logic                hit_r;
  logic                out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dlo_nxt[a]   = {lo0_r[a][W-1], lo0_r[a]} - {o0_r[a][W-1], o0_r[a]};
      dhi_nxt[a]   = {hi0_r[a][W-1], hi0_r[a]} - {o0_r[a][W-1], o0_r[a]};
      mlo_nxt[a]   = dlo_nxt[a][W] ? -dlo_nxt[a] : dlo_nxt[a];
      mhi_nxt[a]   = dhi_nxt[a][W] ? -dhi_nxt[a] : dhi_nxt[a];
      md_nxt[a]    = d0_r[a][W-1] ? -d0_r[a] : d0_r[a];
      neglo_nxt[a] = dlo_nxt[a][W] ^ d0_r[a][W-1];
      neghi_nxt[a] = dhi_nxt[a][W] ^ d0_r[a][W-1];
      skip_nxt[a]  = d0_r[a] == '0;
    end
    side_nxt = {o0_r[0], o0_r[1], o0_r[2], d0_r[0], d0_r[1], d0_r[2],
                neglo_nxt, neghi_nxt, skip_nxt};
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    rbs_div #(.N(NW), .D(W)) u_div_lo (
      .clk      (clk),
      .en       (en),
      .dividend ({mlo_nxt[a], {F{1'b0}}}),
      .divisor  (md_nxt[a]),
      .quotient (qlo[a])
    );
    rbs_div #(.N(NW), .D(W)) u_div_hi (
      .clk      (clk),
      .en       (en),
      .dividend ({mhi_nxt[a], {F{1'b0}}}),
      .divisor  (md_nxt[a]),
      .quotient (qhi[a])
    );
  end

  assign {os[0], os[1], os[2], ds[0], ds[1], ds[2], nlos, nhis, skips} = side_r[NW-1];

  always_comb begin
    tin_nxt  = '0;
    tout_nxt = '0;
    any_nxt  = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (!skipd_r[a]) begin
        if (!any_nxt) begin
          tin_nxt  = near_r[a];
          tout_nxt = far_r[a];
        end else begin
          if (near_r[a] > tin_nxt) tin_nxt = near_r[a];
          if (far_r[a] < tout_nxt) tout_nxt = far_r[a];
        end
        any_nxt = 1'b1;
      end
    end
    amin_nxt  = tin_r[TW-1] ? -tin_r : tin_r;
    amout_nxt = tout_r[TW-1] ? -tout_r : tout_r;
  end

  for (genvar p = 0; p < NUM_POINTS; p++) begin : g_point
    logic [QW-1:0]       q;
    logic                cap_hit;
    logic [W:0]          qc;
    logic [W+1:0]        mag;
    logic signed [W+1:0] v;
    logic signed [W+1:0] sum;
    logic signed [W-1:0] o;

    assign o       = oh_r[p % NUM_AXES];
    assign q       = prod_r[p][PW-1:F];
    assign cap_hit = (|q[QW-1:W+1]) || (q[W] && (|q[W-1:0]));
    assign qc      = cap_hit ? {1'b1, {W{1'b0}}} : q[W:0];
    assign mag     = {1'b0, qc};
    assign v       = negh_r[p] ? -mag : mag;
    assign sum     = {o[W-1], o[W-1], o} + v;

    always_comb begin
      if (!hith_r) begin
        pt_nxt[p] = '0;
      end else if (sum[W+1] != sum[W] || sum[W] != sum[W-1]) begin
        pt_nxt[p] = sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        pt_nxt[p] = sum[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      sv_r        <= '0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      vg_r        <= 1'b0;
      vh_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r     <= in_valid;
      o0_r[0]  <= in_ray_origin_x;
      o0_r[1]  <= in_ray_origin_y;
      o0_r[2]  <= in_ray_origin_z;
      d0_r[0]  <= in_ray_dir_x;
      d0_r[1]  <= in_ray_dir_y;
      d0_r[2]  <= in_ray_dir_z;
      lo0_r[0] <= in_box_min_x;
      lo0_r[1] <= in_box_min_y;
      lo0_r[2] <= in_box_min_z;
      hi0_r[0] <= in_box_max_x;
      hi0_r[1] <= in_box_max_y;
      hi0_r[2] <= in_box_max_z;

      side_r[0] <= side_nxt;
      sv_r      <= {sv_r[NW-2:0], v0_r};
      for (int k = 1; k < NW; k++) begin
        side_r[k] <= side_r[k-1];
      end

      vc_r    <= sv_r[NW-1];
      skipc_r <= skips;
      for (int a = 0; a < NUM_AXES; a++) begin
        t1_r[a] <= nlos[a] ? -{1'b0, qlo[a]} : {1'b0, qlo[a]};
        t2_r[a] <= nhis[a] ? -{1'b0, qhi[a]} : {1'b0, qhi[a]};
        oc_r[a] <= os[a];
        dc_r[a] <= ds[a];
      end

      vd_r    <= vc_r;
      skipd_r <= skipc_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        near_r[a] <= (t1_r[a] < t2_r[a]) ? t1_r[a] : t2_r[a];
        far_r[a]  <= (t1_r[a] < t2_r[a]) ? t2_r[a] : t1_r[a];
        od_r[a]   <= oc_r[a];
        dd_r[a]   <= dc_r[a];
      end

      ve_r   <= vd_r;
      tin_r  <= tin_nxt;
      tout_r <= tout_nxt;
      hite_r <= !((tin_nxt > tout_nxt) || (tout_nxt < 0));
      for (int a = 0; a < NUM_AXES; a++) begin
        oe_r[a] <= od_r[a];
        de_r[a] <= dd_r[a];
      end

      vf_r    <= ve_r;
      hitf_r  <= hite_r;
      mtin_r  <= amin_nxt[NW-1:0];
      mtout_r <= amout_nxt[NW-1:0];
      for (int a = 0; a < NUM_AXES; a++) begin
        mdf_r[a]             <= de_r[a][W-1] ? -de_r[a] : de_r[a];
        negf_r[a]            <= tin_r[TW-1] ^ de_r[a][W-1];
        negf_r[a + NUM_AXES] <= tout_r[TW-1] ^ de_r[a][W-1];
        of_r[a]              <= oe_r[a];
      end

      vg_r   <= vf_r;
      hitg_r <= hitf_r;
      negg_r <= negf_r;
      for (int a = 0; a < NUM_AXES; a++) begin
        plo_r[a]            <= (HL + W)'(mtin_r[HL-1:0]) * (HL + W)'(mdf_r[a]);
        phi_r[a]            <= (HH + W)'(mtin_r[NW-1:HL]) * (HH + W)'(mdf_r[a]);
        plo_r[a + NUM_AXES] <= (HL + W)'(mtout_r[HL-1:0]) * (HL + W)'(mdf_r[a]);
        phi_r[a + NUM_AXES] <= (HH + W)'(mtout_r[NW-1:HL]) * (HH + W)'(mdf_r[a]);
        og_r[a]             <= of_r[a];
      end

      vh_r   <= vg_r;
      hith_r <= hitg_r;
      negh_r <= negg_r;
      for (int p = 0; p < NUM_POINTS; p++) begin
        prod_r[p] <= (PW'(phi_r[p]) << HL) + PW'(plo_r[p]);
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        oh_r[a] <= og_r[a];
      end

      out_valid_r <= vh_r;
      hit_r       <= hith_r;
      for (int p = 0; p < NUM_POINTS; p++) begin
        pt_r[p] <= pt_nxt[p];
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_entry_x = pt_r[0];
  assign out_entry_y = pt_r[1];
  assign out_entry_z = pt_r[2];
  assign out_exit_x  = pt_r[3];
  assign out_exit_y  = pt_r[4];
  assign out_exit_z  = pt_r[5];

endmodule

// ===== rtl/rbs_checker.sv =====
module rbs_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit,
  input logic signed [COORD_WIDTH-1:0] out_entry_x,
  input logic signed [COORD_WIDTH-1:0] out_entry_y,
  input logic signed [COORD_WIDTH-1:0] out_entry_z,
  input logic signed [COORD_WIDTH-1:0] out_exit_x,
  input logic signed [COORD_WIDTH-1:0] out_exit_y,
  input logic signed [COORD_WIDTH-1:0] out_exit_z
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hit) && $stable(out_entry_x)
      && $stable(out_exit_z))
    else $error("stalled result word changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_entry_x == 0 && out_entry_y == 0
      && out_entry_z == 0 && out_exit_x == 0 && out_exit_y == 0
      && out_exit_z == 0)
    else $error("miss carries non-zero points");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

endmodule

bind ray_box_slab_intersect rbs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rbs_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LATENCY = CW + FB + 9;
  localparam int N_RANDOM = 800;

  typedef struct {
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic signed [CW-1:0] bmin [3];
    logic signed [CW-1:0] bmax [3];
  } ray_box_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] entry [3];
    logic signed [CW-1:0] exitp [3];
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_org [3];
  logic signed [CW-1:0] in_dir [3];
  logic signed [CW-1:0] in_bmin [3];
  logic signed [CW-1:0] in_bmax [3];
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_hit;
  logic signed [CW-1:0] out_entry [3];
  logic signed [CW-1:0] out_exitp [3];

  ray_box_t pending_rays [$];
  isect_t   expected_isects [$];
  int       mismatches = 0;
  bit       stimulus_done = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;

  always #5 clk = ~clk;

  ray_box_slab_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_ray_origin_x(in_org[0]), .in_ray_origin_y(in_org[1]), .in_ray_origin_z(in_org[2]),
    .in_ray_dir_x(in_dir[0]), .in_ray_dir_y(in_dir[1]), .in_ray_dir_z(in_dir[2]),
    .in_box_min_x(in_bmin[0]), .in_box_min_y(in_bmin[1]), .in_box_min_z(in_bmin[2]),
    .in_box_max_x(in_bmax[0]), .in_box_max_y(in_bmax[1]), .in_box_max_z(in_bmax[2]),
    .out_valid(out_valid), .out_stall(out_stall), .out_hit(out_hit),
    .out_entry_x(out_entry[0]), .out_entry_y(out_entry[1]), .out_entry_z(out_entry[2]),
    .out_exit_x(out_exitp[0]), .out_exit_y(out_exitp[1]), .out_exit_z(out_exitp[2])
  );

  function automatic logic signed [CW-1:0] clamp_coord(logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] ray_point(logic signed [CW-1:0] o,
                                                    logic signed [63:0] t,
                                                    logic signed [CW-1:0] d);
    logic signed [127:0] prod;
    logic [127:0] mag;
    logic signed [127:0] step;
    prod = 128'(t) * 128'(d);
    mag = prod < 0 ? 128'(-prod) : 128'(prod);
    mag = mag >> FB;
    if (mag > (128'd1 << CW)) mag = 128'd1 << CW;
    step = prod < 0 ? -$signed(mag) : $signed(mag);
    return clamp_coord(128'(o) + step);
  endfunction

  function automatic isect_t slab_intersect(ray_box_t r);
    isect_t res;
    logic signed [63:0] t_entry;
    logic signed [63:0] t_exit;
    logic signed [63:0] t1;
    logic signed [63:0] t2;
    logic signed [63:0] tn;
    logic signed [63:0] tf;
    bit any;
    t_entry = 0;
    t_exit = 0;
    any = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (r.dir[a] != 0) begin
        t1 = ((64'(r.bmin[a]) - 64'(r.org[a])) <<< FB) / 64'(r.dir[a]);
        t2 = ((64'(r.bmax[a]) - 64'(r.org[a])) <<< FB) / 64'(r.dir[a]);
        tn = t1 < t2 ? t1 : t2;
        tf = t1 < t2 ? t2 : t1;
        if (!any) begin
          t_entry = tn;
          t_exit = tf;
          any = 1'b1;
        end else begin
          if (tn > t_entry) t_entry = tn;
          if (tf < t_exit) t_exit = tf;
        end
      end
    end
    res.hit = !(t_entry > t_exit || t_exit < 0);
    for (int a = 0; a < 3; a++) begin
      res.entry[a] = res.hit ? ray_point(r.org[a], t_entry, r.dir[a]) : '0;
      res.exitp[a] = res.hit ? ray_point(r.org[a], t_exit, r.dir[a]) : '0;
    end
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord(int kind);
    logic signed [CW-1:0] v;
    case (kind)
      0: v = $urandom;
      1: v = $signed(CW'($urandom_range(0, 32'h0040_0000))) - 32'sh0020_0000;
      2: v = $signed(CW'($urandom_range(0, 16))) - 8;
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b0, {(CW-1){1'b1}}};
          1: v = {1'b1, {(CW-1){1'b0}}};
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic int pick_kind();
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) return 0;
    if (p < 80) return 1;
    if (p < 90) return 2;
    return 3;
  endfunction

  function automatic ray_box_t random_ray();
    ray_box_t r;
    for (int a = 0; a < 3; a++) begin
      r.org[a] = rand_coord(pick_kind());
      r.dir[a] = ($urandom_range(0, 9) == 0) ? '0 : rand_coord(pick_kind());
      r.bmin[a] = rand_coord(pick_kind());
      r.bmax[a] = rand_coord(pick_kind());
      if ($urandom_range(0, 3) != 0 && r.bmin[a] > r.bmax[a]) begin
        r.bmin[a] = r.bmax[a] ^ r.bmin[a];
        r.bmax[a] = r.bmax[a] ^ r.bmin[a];
        r.bmin[a] = r.bmax[a] ^ r.bmin[a];
      end
    end
    return r;
  endfunction

  function automatic ray_box_t make_ray(logic signed [CW-1:0] o, logic signed [CW-1:0] d,
                                        logic signed [CW-1:0] lo, logic signed [CW-1:0] hi);
    ray_box_t r;
    for (int a = 0; a < 3; a++) begin
      r.org[a] = o;
      r.dir[a] = d;
      r.bmin[a] = lo;
      r.bmax[a] = hi;
    end
    return r;
  endfunction

  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void add_ray(ray_box_t r);
    pending_rays.insert(pending_rays.size(), r);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      ray_box_t r;
      r.org = in_org;
      r.dir = in_dir;
      r.bmin = in_bmin;
      r.bmax = in_bmax;
      expected_isects.insert(expected_isects.size(), slab_intersect(r));
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_rays.size() > 0) begin
        ray_box_t r;
        r = pending_rays.pop_front();
        in_org <= r.org;
        in_dir <= r.dir;
        in_bmin <= r.bmin;
        in_bmax <= r.bmax;
        in_valid <= 1'b1;
        in_gap <= (($urandom_range(0, 999) / 250) == 1) ? gap_length() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_isects.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word, hit=%0b", out_hit);
      end else begin
        isect_t e;
        bit bad;
        e = expected_isects.pop_front();
        bad = (out_hit !== e.hit);
        for (int a = 0; a < 3; a++)
          bad |= (out_entry[a] !== e.entry[a]) || (out_exitp[a] !== e.exitp[a]);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected hit %0b entry %0d %0d %0d exit %0d %0d %0d",
                     e.hit, e.entry[0], e.entry[1], e.entry[2],
                     e.exitp[0], e.exitp[1], e.exitp[2]);
            $display("          actual   hit %0b entry %0d %0d %0d exit %0d %0d %0d",
                     out_hit, out_entry[0], out_entry[1], out_entry[2],
                     out_exitp[0], out_exitp[1], out_exitp[2]);
          end
        end
      end
    end
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_gap <= gap_length();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    ray_box_t r;
    for (int a = 0; a < 3; a++) begin
      in_org[a] = '0;
      in_dir[a] = '0;
      in_bmin[a] = '0;
      in_bmax[a] = '0;
    end
    add_ray(make_ray(0, 0, -32'sh10000, 32'sh10000));
    add_ray(make_ray(0, 32'sh10000, -32'sh10000, 32'sh10000));
    add_ray(make_ray(0, -32'sh10000, 32'sh10000, -32'sh10000));
    add_ray(make_ray(32'sh50000, 32'sh10000, 0, 32'sh10000));
    add_ray(make_ray(0, 32'sh10000, 0, 32'sh20000));
    add_ray(make_ray(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
    add_ray(make_ray(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff));
    add_ray(make_ray(32'sh80000000, 1, 32'sh80000000, 32'sh7fffffff));
    add_ray(make_ray(32'sh7fffffff, -1, 32'sh80000000, 32'sh7fffffff));
    add_ray(make_ray(-1, -1, -1, -1));
    r = make_ray(0, 0, -32'sh10000, 32'sh10000);
    r.dir[1] = 32'sh8000;
    add_ray(r);
    r.org[0] = 32'sh30000;
    add_ray(r);
    r = make_ray(0, 32'sh10000, 32'sh10000, 32'sh20000);
    r.dir[2] = -32'sh10000;
    add_ray(r);
    for (int i = 0; i < N_RANDOM; i++) add_ray(random_ray());
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_rays.size() == 0 && !in_valid);
    wait (expected_isects.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_isects.size() == 0) begin
      $display("[ray_box_slab_intersect] OK");
    end else begin
      $display("[ray_box_slab_intersect] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[ray_box_slab_intersect] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rbs_pkg.sv
rtl/rbs_div.sv
rtl/ray_box_slab_intersect.sv
rtl/rbs_checker.sv
test/tb.sv
